// File: rtl/core/pga_pkg.sv
// Package with shared constants, codes and types of the page allocator.
package pga_pkg;

	localparam int NUM_PAGES_DEF = 32768;
	localparam int PAGE_BITS_DEF = 12;

	localparam int CMD_W = 3;
	localparam int STATUS_W = 3;
	localparam int CNT_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FREE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INC = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEC = 3'd3;
	localparam logic [CMD_W-1:0] CMD_GET = 3'd4;

	localparam logic [STATUS_W-1:0] STS_OK = 3'd0;
	localparam logic [STATUS_W-1:0] STS_OOM = 3'd1;
	localparam logic [STATUS_W-1:0] STS_BAD_FREE = 3'd2;
	localparam logic [STATUS_W-1:0] STS_IGNORED = 3'd3;
	localparam logic [STATUS_W-1:0] STS_SATURATED = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MEM_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHYS_TOP = 2'd2;

	localparam logic [31:0] MEM_BASE_RST = 32'h8000_0000;
	localparam logic [31:0] KERNEL_END_RST = 32'h8002_0000;
	localparam logic [31:0] PHYS_TOP_RST = 32'h8800_0000;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DEC,
		ST_EXEC
	} state_t;

endpackage

// File: rtl/core/pga_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pga_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/page_allocator_with_refcounts.sv
// Top level of the page allocator with per-page reference counts.
//
// Commands arrive on the input channel (in_valid, in_stall, cmd, addr), one per
// transaction, and each gives exactly one result transaction on the output
// channel (out_valid, out_stall, page_addr, ref_count, status).
// A command is decoded in the cycle after it is accepted, the reference count and
// free stack memories are read, and in the execute step the result is formed,
// written back and placed in the output register. A new command can be accepted
// in the execute step of the one before but not during its decode, limited by the
// read-modify-write of the count memory and the stack memory.
// The output register holds a result while out_stall is high; a command in
// flight then waits in its execute cycle and the input stalls.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always
// ready; each write to a known register empties the free stack and recomputes the
// untouched page range in the next cycle, during which the input stalls.
// After reset the count memory is cleared one entry a cycle, all NUM_PAGES entries
// in turn, while the input stalls; configuration writes are taken meanwhile.
module page_allocator_with_refcounts #(
	parameter int NUM_PAGES = pga_pkg::NUM_PAGES_DEF,
	parameter int PAGE_BITS = pga_pkg::PAGE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pga_pkg::CMD_W-1:0]      cmd,
	input  logic [31:0]                    addr,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [31:0]                    page_addr,
	output logic [pga_pkg::CNT_W-1:0]      ref_count,
	output logic [pga_pkg::STATUS_W-1:0]   status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pga_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);

	import pga_pkg::*;

	localparam int PIDX_W = $clog2(NUM_PAGES);
	localparam int MARK_W = $clog2(NUM_PAGES + 1);
	localparam logic [32:0] PAGE_SIZE = 33'(1) << PAGE_BITS;

	state_t state_q, state_d;

	logic [31:0] mem_base_q, kernel_end_q, phys_top_q;
	logic        start_q;
	logic [MARK_W-1:0] floor_q, mark_q, mark_d;
	logic [MARK_W-1:0] depth_q, depth_d;
	logic [PIDX_W-1:0] clr_q;

	logic [CMD_W-1:0] cmd_s1, cmd_s2;
	logic [31:0]      addr_s1;
	logic [PIDX_W-1:0] idx_s2;
	logic             inrange_s2, aligned_s2;

	logic out_valid_q;
	logic [31:0] page_addr_q;
	logic [CNT_W-1:0] ref_count_q;
	logic [STATUS_W-1:0] status_q;

	logic cfg_fire, in_fire, exec_fire, rd_en, out_free;

	logic [31:0] dec_diff, dec_page;
	logic        dec_inrange;

	logic [32:0] lo_full, hi_full, hi_cap, lo_cap;

	logic              cw_we, sw_we, cnt_we;
	logic [PIDX_W-1:0] cw_addr, cnt_waddr, sw_addr, p;
	logic [CNT_W-1:0]  cw_data, cnt_wdata, cnt_rd;
	logic [PIDX_W-1:0] stack_rd;
	logic [31:0]       res_page;
	logic [CNT_W-1:0]  res_cnt;
	logic [STATUS_W-1:0] res_stat;

	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid;
	assign in_fire = in_valid && !in_stall;

	// Start-up pass: bounds of the untouched page range.
	always_comb begin
		lo_full = '0;
		hi_full = '0;
		if (kernel_end_q > mem_base_q) begin
			lo_full = ({1'b0, kernel_end_q - mem_base_q} + (PAGE_SIZE - 33'd1)) >> PAGE_BITS;
		end
		if (phys_top_q >= mem_base_q) begin
			hi_full = {1'b0, phys_top_q - mem_base_q} >> PAGE_BITS;
		end
		hi_cap = (hi_full > 33'(NUM_PAGES)) ? 33'(NUM_PAGES) : hi_full;
		lo_cap = (lo_full > hi_cap) ? hi_cap : lo_full;
	end

	// Address decode of the accepted command.
	always_comb begin
		dec_diff = addr_s1 - mem_base_q;
		dec_page = dec_diff >> PAGE_BITS;
		dec_inrange = (addr_s1 >= kernel_end_q) && (addr_s1 < phys_top_q)
			&& (addr_s1 >= mem_base_q) && (dec_page < 32'(NUM_PAGES));
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		rd_en = 1'b0;
		exec_fire = 1'b0;
		out_free = !out_valid_q || !out_stall;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == PIDX_W'(NUM_PAGES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = start_q;
				if (in_valid && !start_q) begin
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				rd_en = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				in_stall = !out_free || start_q;
				if (out_free) begin
					exec_fire = 1'b1;
					state_d = (in_valid && !start_q) ? ST_DEC : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Execute step: result and write-back of one command.
	always_comb begin
		cw_we = 1'b0;
		cw_addr = idx_s2;
		cw_data = '0;
		sw_we = 1'b0;
		sw_addr = depth_q[PIDX_W-1:0];
		depth_d = depth_q;
		mark_d = mark_q;
		res_page = '0;
		res_cnt = '0;
		res_stat = STS_OK;
		p = '0;
		case (cmd_s2) inside
			CMD_ALLOC: begin
				if (depth_q != '0) begin
					p = stack_rd;
					depth_d = depth_q - 1'b1;
				end else if (mark_q > floor_q) begin
					p = PIDX_W'(mark_q - 1'b1);
					mark_d = mark_q - 1'b1;
				end else begin
					res_stat = STS_OOM;
				end
				if (res_stat == STS_OK) begin
					cw_we = 1'b1;
					cw_addr = p;
					cw_data = 8'd1;
					res_page = mem_base_q + (32'(p) << PAGE_BITS);
				end
			end
			CMD_FREE: begin
				if (!aligned_s2 || !inrange_s2) begin
					res_stat = STS_BAD_FREE;
				end else if (cnt_rd > 8'd1) begin
					cw_we = 1'b1;
					cw_data = cnt_rd - 8'd1;
				end else begin
					cw_we = 1'b1;
					cw_data = '0;
					if (depth_q < MARK_W'(NUM_PAGES)) begin
						sw_we = 1'b1;
						depth_d = depth_q + 1'b1;
					end else begin
						res_stat = STS_BAD_FREE;
					end
				end
			end
			CMD_INC, CMD_DEC, CMD_GET: begin
				if (!inrange_s2) begin
					res_stat = STS_IGNORED;
				end else if (cmd_s2 == CMD_INC) begin
					if (cnt_rd == 8'hFF) begin
						res_stat = STS_SATURATED;
					end else begin
						cw_we = 1'b1;
						cw_data = cnt_rd + 8'd1;
					end
				end else if (cmd_s2 == CMD_DEC) begin
					if (cnt_rd == 8'd0) begin
						res_stat = STS_SATURATED;
					end else begin
						cw_we = 1'b1;
						cw_data = cnt_rd - 8'd1;
					end
				end else begin
					res_cnt = cnt_rd;
				end
			end
			default: begin
				res_stat = STS_IGNORED;
			end
		endcase
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			cnt_we = 1'b1;
			cnt_waddr = clr_q;
			cnt_wdata = '0;
		end else begin
			cnt_we = cw_we && exec_fire;
			cnt_waddr = cw_addr;
			cnt_wdata = cw_data;
		end
	end

	pga_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NUM_PAGES)
	) u_counts (
		.clk(clk),
		.we(cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.re(rd_en),
		.raddr(dec_page[PIDX_W-1:0]),
		.rdata(cnt_rd)
	);

	pga_ram #(
		.WIDTH(PIDX_W),
		.DEPTH(NUM_PAGES)
	) u_stack (
		.clk(clk),
		.we(sw_we && exec_fire),
		.waddr(sw_addr),
		.wdata(idx_s2),
		.re(rd_en),
		.raddr(PIDX_W'(depth_q - 1'b1)),
		.rdata(stack_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_base_q <= MEM_BASE_RST;
			kernel_end_q <= KERNEL_END_RST;
			phys_top_q <= PHYS_TOP_RST;
			start_q <= 1'b1;
			floor_q <= '0;
			mark_q <= '0;
			depth_q <= '0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				unique case (cfg_index)
					REG_MEM_BASE: mem_base_q <= cfg_data;
					REG_KERNEL_END: kernel_end_q <= cfg_data;
					REG_PHYS_TOP: phys_top_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (start_q) begin
				floor_q <= lo_cap[MARK_W-1:0];
				mark_q <= hi_cap[MARK_W-1:0];
				depth_q <= '0;
			end else if (exec_fire) begin
				mark_q <= mark_d;
				depth_q <= depth_d;
			end
			start_q <= cfg_fire && (cfg_index == REG_MEM_BASE || cfg_index == REG_KERNEL_END
				|| cfg_index == REG_PHYS_TOP);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (exec_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1 <= cmd;
			addr_s1 <= addr;
		end
		if (state_q == ST_DEC) begin
			cmd_s2 <= cmd_s1;
			idx_s2 <= dec_page[PIDX_W-1:0];
			inrange_s2 <= dec_inrange;
			aligned_s2 <= (addr_s1[PAGE_BITS-1:0] == '0);
		end
		if (exec_fire) begin
			page_addr_q <= res_page;
			ref_count_q <= res_cnt;
			status_q <= res_stat;
		end
	end

	assign out_valid = out_valid_q;
	assign page_addr = page_addr_q;
	assign ref_count = ref_count_q;
	assign status = status_q;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the page allocator with per-page reference counts.
`timescale 1ns / 1ps

module tb_top;
	import pga_pkg::*;

	localparam int N_PAGES = NUM_PAGES_DEF;
	localparam int PG_BITS = PAGE_BITS_DEF;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNDEF_MID = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic [31:0] a;
	} page_cmd_t;

	typedef struct packed {
		logic [31:0] page_addr;
		logic [CNT_W-1:0] ref_count;
		logic [STATUS_W-1:0] status;
	} page_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_W-1:0] cmd = '0;
	logic [31:0] addr = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] page_addr;
	logic [CNT_W-1:0] ref_count;
	logic [STATUS_W-1:0] status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	page_cmd_t cmd_backlog[$];
	page_result_t due_results[$];
	int fail_count = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int stall_left = 0;
	int rx_hold = 0;
	logic quiet = 1'b0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;

	// Shadow of the allocator state.
	logic [31:0] mem_base;
	logic [31:0] kernel_end;
	logic [31:0] phys_top;
	logic [14:0] free_pages [N_PAGES];
	logic [CNT_W-1:0] page_refs [N_PAGES];
	int unsigned stack_top;
	int unsigned next_fresh;
	int unsigned fresh_floor;

	page_allocator_with_refcounts dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.addr(addr),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.page_addr(page_addr),
		.ref_count(ref_count),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic void rebuild_region();
		logic [32:0] lo;
		logic [32:0] hi;
		lo = '0;
		hi = '0;
		if (kernel_end > mem_base)
			lo = ({1'b0, kernel_end} - {1'b0, mem_base} + ((33'(1) << PG_BITS) - 33'd1))
				>> PG_BITS;
		if (phys_top >= mem_base)
			hi = ({1'b0, phys_top} - {1'b0, mem_base}) >> PG_BITS;
		if (hi > 33'(N_PAGES))
			hi = 33'(N_PAGES);
		if (lo > hi)
			lo = hi;
		fresh_floor = 32'(lo);
		next_fresh = 32'(hi);
		stack_top = 0;
	endfunction

	function automatic int page_index(logic [31:0] a);
		logic [31:0] off;
		if (a < kernel_end || a >= phys_top || a < mem_base)
			return -1;
		off = (a - mem_base) >> PG_BITS;
		if (off >= 32'(N_PAGES))
			return -1;
		return int'(off);
	endfunction

	function automatic page_result_t run_page_cmd(logic [CMD_W-1:0] op, logic [31:0] a);
		page_result_t r;
		int idx;
		int unsigned p;
		r = '0;
		idx = page_index(a);
		case (op) inside
			CMD_ALLOC: begin
				if (stack_top > 0) begin
					stack_top--;
					p = 32'(free_pages[stack_top]);
				end else if (next_fresh > fresh_floor) begin
					next_fresh--;
					p = next_fresh;
				end else begin
					r.status = STS_OOM;
					return r;
				end
				page_refs[p] = 8'd1;
				r.page_addr = mem_base + (p << PG_BITS);
			end
			CMD_FREE: begin
				if (a[PG_BITS-1:0] != '0 || idx < 0) begin
					r.status = STS_BAD_FREE;
				end else if (page_refs[idx] > 1) begin
					page_refs[idx]--;
				end else begin
					page_refs[idx] = '0;
					if (stack_top < N_PAGES) begin
						free_pages[stack_top] = 15'(idx);
						stack_top++;
					end else begin
						r.status = STS_BAD_FREE;
					end
				end
			end
			CMD_INC, CMD_DEC, CMD_GET: begin
				if (idx < 0) begin
					r.status = STS_IGNORED;
				end else if (op == CMD_INC) begin
					if (page_refs[idx] == 8'hFF)
						r.status = STS_SATURATED;
					else
						page_refs[idx]++;
				end else if (op == CMD_DEC) begin
					if (page_refs[idx] == 8'h00)
						r.status = STS_SATURATED;
					else
						page_refs[idx]--;
				end else begin
					r.ref_count = page_refs[idx];
				end
			end
			default: r.status = STS_IGNORED;
		endcase
		return r;
	endfunction

	// Command driver.
	always @(posedge clk) begin
		page_cmd_t nxt;
		if (arst_n && (!in_valid || !in_stall)) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (cmd_backlog.size() != 0) begin
				nxt = cmd_backlog.pop_front();
				in_valid <= 1'b1;
				cmd <= nxt.op;
				addr <= nxt.a;
				if (!quiet && $urandom_range(0, 5) == 0)
					send_gap <= $urandom_range(1, 5);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver stalls.
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			out_stall <= 1'b1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 6) == 0) begin
			stall_left <= $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// One long hold-off of the receiver so that the block backs up.
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			rx_hold <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
		end
	end

	// Monitor: predicts on each accepted command and checks each accepted result.
	always @(posedge clk) begin
		page_result_t got;
		page_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{page_addr: page_addr, ref_count: ref_count, status: status};
			if (due_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("ERROR: unexpected result page_addr=%h ref_count=%0d status=%0d",
						got.page_addr, got.ref_count, got.status);
			end else begin
				want = due_results.pop_front();
				if (got.page_addr !== want.page_addr || got.ref_count !== want.ref_count ||
						got.status !== want.status) begin
					fail_count++;
					if (fail_count <= 10)
						$display("ERROR: expected page_addr=%h ref_count=%0d status=%0d, got page_addr=%h ref_count=%0d status=%0d",
							want.page_addr, want.ref_count, want.status,
							got.page_addr, got.ref_count, got.status);
				end
			end
		end
		if (arst_n && in_valid && !in_stall)
			due_results.push_back(run_page_cmd(cmd, addr));
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic post(input logic [CMD_W-1:0] op, input logic [31:0] a);
		cmd_backlog.push_back('{op: op, a: a});
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MEM_BASE: mem_base = val;
			REG_KERNEL_END: kernel_end = val;
			REG_PHYS_TOP: phys_top = val;
			default: ;
		endcase
		if (idx != REG_UNUSED)
			rebuild_region();
		@(negedge clk);
	endtask

	task automatic settle();
		do @(negedge clk); while (cmd_backlog.size() != 0 || in_valid || due_results.size() != 0);
	endtask

	// Mostly allocs and frees of pages in a small window, with some count traffic and noise.
	task automatic random_traffic(input int n, input logic [31:0] win, input int pages);
		logic [31:0] pg;
		int pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			pg = win + ($urandom_range(0, pages - 1) << PG_BITS);
			if (pick < 35)
				post(CMD_ALLOC, $urandom);
			else if (pick < 62)
				post(CMD_FREE, pg);
			else if (pick < 72)
				post(CMD_INC, pg | $urandom_range(0, 4095));
			else if (pick < 80)
				post(CMD_DEC, pg);
			else if (pick < 90)
				post(CMD_GET, pg | $urandom_range(0, 4095));
			else if (pick < 95)
				post(CMD_FREE, pg | $urandom_range(1, 4095));
			else
				post(CMD_W'($urandom_range(0, 7)), $urandom);
		end
	endtask

	initial begin
		mem_base = MEM_BASE_RST;
		kernel_end = KERNEL_END_RST;
		phys_top = PHYS_TOP_RST;
		foreach (page_refs[i])
			page_refs[i] = '0;
		foreach (free_pages[i])
			free_pages[i] = '0;
		rebuild_region();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed commands on the configuration after reset.
		post(CMD_ALLOC, 32'h0000_0000);
		post(CMD_ALLOC, 32'hFFFF_FFFF);
		post(CMD_GET, 32'h87FF_F000);
		post(CMD_INC, 32'h87FF_E000);
		post(CMD_FREE, 32'h87FF_E000);
		post(CMD_GET, 32'h87FF_E123);
		post(CMD_FREE, 32'h87FF_F000);
		post(CMD_ALLOC, 32'h0000_0000);
		post(CMD_DEC, 32'h8002_0000);
		post(CMD_FREE, 32'h87FF_E004);
		post(CMD_FREE, 32'h8000_0000);
		post(CMD_FREE, 32'h8800_0000);
		post(CMD_FREE, 32'hFFFF_F000);
		post(CMD_FREE, 32'h0000_0000);
		post(CMD_INC, 32'h7FFF_F000);
		post(CMD_GET, 32'h0000_0000);
		post(CMD_DEC, 32'hFFFF_FFFF);
		post(CMD_UNDEF_LO, 32'h87FF_F000);
		post(CMD_UNDEF_MID, 32'hFFFF_FFFF);
		post(CMD_UNDEF_HI, 32'h0000_0000);
		post(CMD_FREE, 32'h8002_0000);
		post(CMD_FREE, 32'h8002_0000);
		post(CMD_ALLOC, 32'h0000_0000);
		post(CMD_ALLOC, 32'h0000_0000);
		post(CMD_GET, 32'h87FF_FFFF);
		post(CMD_GET, 32'h8002_0000);
		settle();

		// Eight managed pages: out of memory is reached, receiver holds off once.
		write_reg(REG_KERNEL_END, 32'h8000_0000);
		write_reg(REG_PHYS_TOP, 32'h8000_8000);
		random_traffic(50, 32'h8000_0000, 8);
		hold_req = 1'b1;
		settle();

		// Whole address space as the configured range, wider than the NUM_PAGES managed pages.
		write_reg(REG_MEM_BASE, 32'h0000_0000);
		write_reg(REG_KERNEL_END, 32'h0000_0000);
		write_reg(REG_PHYS_TOP, 32'hFFFF_FFFF);
		post(CMD_FREE, 32'h0800_0000);
		post(CMD_GET, 32'h07FF_FFFF);
		random_traffic(25, 32'h07FF_8000, 8);
		settle();

		// No managed page at all at the top of the address space.
		write_reg(REG_MEM_BASE, 32'hFFFF_F000);
		write_reg(REG_KERNEL_END, 32'hFFFF_FFFF);
		post(CMD_ALLOC, 32'h0000_0000);
		post(CMD_FREE, 32'hFFFF_F000);
		post(CMD_GET, 32'hFFFF_FFFE);
		post(CMD_INC, 32'hFFFF_FFFF);
		settle();

		// Unaligned kernel end: the partial page is counted but never handed out.
		write_reg(REG_MEM_BASE, 32'hFFFF_0000);
		write_reg(REG_KERNEL_END, 32'hFFFF_1801);
		post(CMD_FREE, 32'hFFFF_1000);
		post(CMD_INC, 32'hFFFF_1900);
		post(CMD_GET, 32'hFFFF_1900);
		random_traffic(30, 32'hFFFF_1000, 15);
		settle();

		// All registers at zero, plus a write to the unused index.
		write_reg(REG_MEM_BASE, 32'h0000_0000);
		write_reg(REG_KERNEL_END, 32'h0000_0000);
		write_reg(REG_PHYS_TOP, 32'h0000_0000);
		write_reg(REG_UNUSED, $urandom);
		post(CMD_ALLOC, 32'h0000_0000);
		post(CMD_FREE, 32'h0000_0000);
		post(CMD_GET, 32'h0000_0000);
		post(CMD_INC, 32'hFFFF_FFFF);
		settle();

		// Repeated frees of one page: each that finds its count at most one pushes it, and it is handed out again.
		write_reg(REG_MEM_BASE, 32'h8000_0000);
		write_reg(REG_KERNEL_END, 32'h8000_0000);
		write_reg(REG_PHYS_TOP, 32'h8000_4000);
		repeat (3)
			post(CMD_FREE, 32'h8000_0000);
		repeat (3)
			post(CMD_ALLOC, 32'h0000_0000);
		post(CMD_GET, 32'h8000_0000);
		settle();

		// Back to the reset configuration: count saturation, then random traffic.
		write_reg(REG_MEM_BASE, MEM_BASE_RST);
		write_reg(REG_KERNEL_END, KERNEL_END_RST);
		write_reg(REG_PHYS_TOP, PHYS_TOP_RST);
		post(CMD_ALLOC, 32'h0000_0000);
		repeat (255)
			post(CMD_INC, 32'h87FF_F000);
		post(CMD_GET, 32'h87FF_F000);
		random_traffic(20, 32'h87FF_0000, 16);
		settle();
		quiet = 1'b1;
		random_traffic(20, 32'h87FF_0000, 16);
		settle();
		repeat (4) @(negedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: files.f
rtl/core/pga_pkg.sv
rtl/core/pga_ram.sv
rtl/core/page_allocator_with_refcounts.sv
sim/tb_top.sv
